### src/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types, codes and the micro-program table of the fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;
  localparam int PC_BITS       = 5;
  localparam int PROG_LEN      = 17;

  // Action codes.
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;
  localparam logic [2:0] ACT_POW = 3'd5;

  // Compare order codes.
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]                   action;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
    logic signed [FIELD_BITS-1:0] exponent;
  } rfa_in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic [1:0]                   order;
    logic [1:0]                   status;
  } rfa_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [5:0] {
    OP_END, OP_LOAD, OP_PUBLISH,
    OP_CHK_DEN, OP_CHK_MD, OP_CHK_AD, OP_CHK_DD,
    OP_GCD_ADBD, OP_GCD_G1, OP_GCD_G2, OP_GCD_ND, OP_GREM,
    OP_SAVE_G1, OP_SAVE_G2,
    OP_DIV_ADG, OP_DIV_LA, OP_DIV_LB, OP_DIV_AG1, OP_DIV_BG2,
    OP_DIV_AG2, OP_DIV_BG1, OP_DIV_NG, OP_DIV_DG,
    OP_MUL_L, OP_MUL_TAN, OP_MUL_TBN, OP_MUL_NUM, OP_MUL_DEN,
    OP_CMP_X, OP_CMP_Y, OP_SUM, OP_RED_Z, OP_RED_FIX,
    OP_POW_N, OP_POW_D, OP_PMUL_R, OP_PMUL_B,
    OP_SAVE_PN, OP_SAVE_PD, OP_POW_FIN
  } op_t;

  // How an operation is carried out.
  typedef enum logic [2:0] {K_ONE, K_MUL, K_DIV, K_GCD, K_POW} kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_MUL_WB, S_DIV_WAIT, S_GCD_TEST, S_POW_R, S_POW_B, S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic go;
    logic wb;
  } rfa_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       stop;
    logic       div_rdy;
    logic       gy_zero;
    logic       pm_lsb;
  } rfa_stat_t;

  function automatic kind_t op_kind(op_t op);
    kind_t k;
    case (op) inside
      OP_MUL_L, OP_MUL_TAN, OP_MUL_TBN, OP_MUL_NUM, OP_MUL_DEN,
      OP_CMP_X, OP_CMP_Y, OP_PMUL_R, OP_PMUL_B:            k = K_MUL;
      OP_GREM, OP_DIV_ADG, OP_DIV_LA, OP_DIV_LB, OP_DIV_AG1,
      OP_DIV_BG2, OP_DIV_AG2, OP_DIV_BG1, OP_DIV_NG, OP_DIV_DG: k = K_DIV;
      OP_GCD_ADBD, OP_GCD_G1, OP_GCD_G2, OP_GCD_ND:         k = K_GCD;
      OP_POW_N, OP_POW_D:                                   k = K_POW;
      default:                                              k = K_ONE;
    endcase
    return k;
  endfunction

  // Micro-program of each action. Every program ends in an operation that
  // stops it; past its end the table gives OP_END.
  function automatic op_t prog_op(logic [2:0] act, logic [PC_BITS-1:0] pc);
    op_t op;
    op = OP_END;
    unique case (act)
      ACT_ADD, ACT_SUB: begin
        unique case (pc)
          5'd0:  op = OP_CHK_DEN;
          5'd1:  op = OP_GCD_ADBD;
          5'd2:  op = OP_DIV_ADG;
          5'd3:  op = OP_MUL_L;
          5'd4:  op = OP_CHK_DD;
          5'd5:  op = OP_DIV_LA;
          5'd6:  op = OP_MUL_TAN;
          5'd7:  op = OP_DIV_LB;
          5'd8:  op = OP_MUL_TBN;
          5'd9:  op = OP_SUM;
          5'd10: op = OP_RED_Z;
          5'd11: op = OP_GCD_ND;
          5'd12: op = OP_DIV_NG;
          5'd13: op = OP_DIV_DG;
          5'd14: op = OP_RED_FIX;
          default: op = OP_END;
        endcase
      end
      ACT_MUL, ACT_DIV: begin
        unique case (pc)
          5'd0:  op = OP_CHK_MD;
          5'd1:  op = OP_GCD_G1;
          5'd2:  op = OP_SAVE_G1;
          5'd3:  op = OP_GCD_G2;
          5'd4:  op = OP_SAVE_G2;
          5'd5:  op = OP_DIV_AG1;
          5'd6:  op = OP_DIV_BG2;
          5'd7:  op = OP_MUL_NUM;
          5'd8:  op = OP_DIV_AG2;
          5'd9:  op = OP_DIV_BG1;
          5'd10: op = OP_MUL_DEN;
          5'd11: op = OP_CHK_DD;
          5'd12: op = OP_RED_Z;
          5'd13: op = OP_GCD_ND;
          5'd14: op = OP_DIV_NG;
          5'd15: op = OP_DIV_DG;
          5'd16: op = OP_RED_FIX;
          default: op = OP_END;
        endcase
      end
      ACT_CMP: begin
        unique case (pc)
          5'd0:  op = OP_CHK_DEN;
          5'd1:  op = OP_CMP_X;
          5'd2:  op = OP_CMP_Y;
          default: op = OP_END;
        endcase
      end
      ACT_POW: begin
        unique case (pc)
          5'd0:  op = OP_CHK_AD;
          5'd1:  op = OP_POW_N;
          5'd2:  op = OP_SAVE_PN;
          5'd3:  op = OP_POW_D;
          5'd4:  op = OP_SAVE_PD;
          5'd5:  op = OP_POW_FIN;
          5'd6:  op = OP_RED_Z;
          5'd7:  op = OP_GCD_ND;
          5'd8:  op = OP_DIV_NG;
          5'd9:  op = OP_DIV_DG;
          5'd10: op = OP_RED_FIX;
          default: op = OP_END;
        endcase
      end
      default: op = OP_END;
    endcase
    return op;
  endfunction

endpackage

### src/rfa_div.sv
// ----------------------------------------------------------------------------
// rfa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_div import rfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dvd,
  input  logic [WORD_BITS-1:0] dvs,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem,
  output logic                 done
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    shifted, diff;
  logic          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= dvd;
      dvs_r  <= dvs;
      cnt_r  <= CW'(W - 1);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

`ifndef SYNTHESIS
  // A new division never starts on top of one in progress.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule

### src/rfa_dpath.sv
// ----------------------------------------------------------------------------
// rfa_dpath
// Operand and work registers, multiplier, divider and result registers.
// ----------------------------------------------------------------------------
module rfa_dpath import rfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rfa_in_t   in_data,
  input  rfa_cmd_t  cmd,
  output rfa_stat_t stat,
  output rfa_out_t  out_data
);

  localparam int W = WORD_BITS;

  logic signed [W-1:0]   an_r, ad_r, bn_r, bd_r, ex_r;
  logic signed [W-1:0]   ta_r, tb_r, nn_r, dd_r, pr_r, pb_r;
  logic signed [W-1:0]   res_num_r, res_den_r;
  logic [W-1:0]          gx_r, gy_r, g1_r, g2_r, pm_r;
  logic signed [2*W-1:0] prod_r, px_r;
  logic [2:0]            act_r;
  logic [1:0]            ord_r, st_r;
  logic                  stop_r, q_neg_r;
  rfa_out_t              out_r;

  logic [W-1:0]          dvd_v, dvs_v, dvd_mag, dvs_mag, quo, rem;
  logic                  dvd_uns, dvs_uns, dvd_neg, dvs_neg, div_start, div_done;
  logic signed [W-1:0]   mul_a, mul_b, qs, ga, gb, pbase;
  logic [W-1:0]          ga_mag, gb_mag;
  logic [1:0]            ord_c;
  logic                  an_z, ad_z, bn_z, bd_z;
  kind_t                 kind;

  assign kind = op_kind(cmd.op);
  assign an_z = (an_r == '0);
  assign ad_z = (ad_r == '0);
  assign bn_z = (bn_r == '0);
  assign bd_z = (bd_r == '0);

  // Divider operand selection and sign handling.
  always_comb begin
    dvd_v   = '0;
    dvs_v   = '0;
    dvd_uns = 1'b0;
    dvs_uns = 1'b1;
    case (cmd.op)
      OP_GREM:    begin dvd_v = gx_r; dvd_uns = 1'b1; dvs_v = gy_r; end
      OP_DIV_ADG: begin dvd_v = ad_r; dvs_v = gx_r; end
      OP_DIV_LA:  begin dvd_v = dd_r; dvs_v = ad_r; dvs_uns = 1'b0; end
      OP_DIV_LB:  begin dvd_v = dd_r; dvs_v = bd_r; dvs_uns = 1'b0; end
      OP_DIV_AG1: begin dvd_v = an_r; dvs_v = g1_r; end
      OP_DIV_BG2: begin dvd_v = bn_r; dvs_v = g2_r; end
      OP_DIV_AG2: begin dvd_v = ad_r; dvs_v = g2_r; end
      OP_DIV_BG1: begin dvd_v = bd_r; dvs_v = g1_r; end
      OP_DIV_NG:  begin dvd_v = nn_r; dvs_v = gx_r; end
      OP_DIV_DG:  begin dvd_v = dd_r; dvs_v = gx_r; end
      default:    ;
    endcase
    dvd_neg   = !dvd_uns && dvd_v[W-1];
    dvs_neg   = !dvs_uns && dvs_v[W-1];
    dvd_mag   = dvd_neg ? -dvd_v : dvd_v;
    dvs_mag   = dvs_neg ? -dvs_v : dvs_v;
    div_start = cmd.go && (kind == K_DIV);
    qs        = q_neg_r ? -$signed(quo) : $signed(quo);
  end

  rfa_div #(.WORD_BITS(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (dvd_mag),
    .dvs   (dvs_mag),
    .quo   (quo),
    .rem   (rem),
    .done  (div_done)
  );

  // Multiplier, gcd and power operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_L:   begin mul_a = ta_r; mul_b = bd_r; end
      OP_MUL_TAN: begin mul_a = ta_r; mul_b = an_r; end
      OP_MUL_TBN: begin mul_a = tb_r; mul_b = bn_r; end
      OP_MUL_NUM,
      OP_MUL_DEN: begin mul_a = ta_r; mul_b = tb_r; end
      OP_CMP_X:   begin mul_a = an_r; mul_b = bd_r; end
      OP_CMP_Y:   begin mul_a = bn_r; mul_b = ad_r; end
      OP_PMUL_R:  begin mul_a = pr_r; mul_b = pb_r; end
      OP_PMUL_B:  begin mul_a = pb_r; mul_b = pb_r; end
      default:    ;
    endcase
    ga = '0;
    gb = '0;
    case (cmd.op)
      OP_GCD_ADBD: begin ga = ad_r; gb = bd_r; end
      OP_GCD_G1:   begin ga = an_r; gb = bd_r; end
      OP_GCD_G2:   begin ga = ad_r; gb = bn_r; end
      OP_GCD_ND:   begin ga = nn_r; gb = dd_r; end
      default:     ;
    endcase
    ga_mag = ga[W-1] ? -ga : ga;
    gb_mag = gb[W-1] ? -gb : gb;
    pbase  = (cmd.op == OP_POW_D) ? ad_r : an_r;
    // Exact order of the cross-products, mirrored when the denominators
    // have opposite signs.
    if (px_r < prod_r)       ord_c = ORD_LESS;
    else if (px_r == prod_r) ord_c = ORD_EQUAL;
    else                     ord_c = ORD_GREATER;
    if (ad_r[W-1] != bd_r[W-1]) ord_c = ORD_GREATER - ord_c;
  end

  // Register updates on operation start and write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
    end else begin
      if (cmd.go) begin
        case (kind)
          K_MUL: prod_r  <= mul_a * mul_b;
          K_DIV: q_neg_r <= dvd_neg ^ dvs_neg;
          K_GCD: begin
            if (ga_mag == '0 || gb_mag == '0) begin
              gx_r <= W'(1);
              gy_r <= '0;
            end else begin
              gx_r <= ga_mag;
              gy_r <= gb_mag;
            end
          end
          K_POW: begin
            pr_r <= W'(1);
            pb_r <= pbase;
            pm_r <= ex_r[W-1] ? -ex_r : ex_r;
          end
          default: ;
        endcase
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_LOAD: begin
            act_r <= in_data.action;
            an_r  <= in_data.a_num[W-1:0];
            ad_r  <= in_data.a_den[W-1:0];
            ex_r  <= in_data.exponent[W-1:0];
            if (in_data.action == ACT_DIV) begin
              bn_r <= in_data.b_den[W-1:0];
              bd_r <= in_data.b_num[W-1:0];
            end else if (in_data.action == ACT_SUB) begin
              bn_r <= -in_data.b_num[W-1:0];
              bd_r <= in_data.b_den[W-1:0];
            end else begin
              bn_r <= in_data.b_num[W-1:0];
              bd_r <= in_data.b_den[W-1:0];
            end
            res_num_r <= '0;
            res_den_r <= W'(1);
            ord_r     <= ORD_LESS;
            st_r      <= ST_OK;
            stop_r    <= 1'b0;
          end
          OP_PUBLISH: begin
            if (st_r != ST_OK) begin
              out_r.res_num <= '0;
              out_r.res_den <= '0;
              out_r.order   <= ORD_LESS;
            end else begin
              out_r.res_num <= FIELD_BITS'(res_num_r);
              out_r.res_den <= FIELD_BITS'(res_den_r);
              out_r.order   <= ord_r;
            end
            out_r.status <= st_r;
          end
          OP_END: stop_r <= 1'b1;
          OP_CHK_DEN: begin
            if (ad_z || bd_z) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end
          end
          OP_CHK_MD: begin
            // For divide the second operand is held as its reciprocal.
            if (ad_z || ((act_r == ACT_DIV) ? bn_z : bd_z)) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end else if (act_r == ACT_DIV && bd_z) begin
              st_r   <= ST_DIV_ZERO;
              stop_r <= 1'b1;
            end
          end
          OP_CHK_AD: begin
            if (ad_z) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end
          end
          OP_CHK_DD: begin
            if (dd_r == '0) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end
          end
          OP_GREM: begin
            gx_r <= gy_r;
            gy_r <= rem;
          end
          OP_SAVE_G1: g1_r <= gx_r;
          OP_SAVE_G2: g2_r <= gx_r;
          OP_DIV_ADG, OP_DIV_LA, OP_DIV_AG1, OP_DIV_AG2: ta_r <= qs;
          OP_DIV_LB, OP_DIV_BG2, OP_DIV_BG1:             tb_r <= qs;
          OP_DIV_NG: nn_r <= qs;
          OP_DIV_DG: dd_r <= qs;
          OP_MUL_L:   dd_r <= prod_r[W-1:0];
          OP_MUL_TAN: ta_r <= prod_r[W-1:0];
          OP_MUL_TBN: tb_r <= prod_r[W-1:0];
          OP_MUL_NUM: nn_r <= prod_r[W-1:0];
          OP_MUL_DEN: dd_r <= prod_r[W-1:0];
          OP_CMP_X:   px_r <= prod_r;
          OP_CMP_Y: begin
            ord_r  <= ord_c;
            stop_r <= 1'b1;
          end
          OP_SUM: nn_r <= ta_r + tb_r;
          OP_RED_Z: begin
            if (nn_r == '0) begin
              res_num_r <= '0;
              res_den_r <= W'(1);
              stop_r    <= 1'b1;
            end
          end
          OP_RED_FIX: begin
            if (dd_r[W-1]) begin
              res_num_r <= -nn_r;
              res_den_r <= -dd_r;
            end else begin
              res_num_r <= nn_r;
              res_den_r <= dd_r;
            end
            stop_r <= 1'b1;
          end
          OP_PMUL_R: pr_r <= prod_r[W-1:0];
          OP_PMUL_B: begin
            pb_r <= prod_r[W-1:0];
            pm_r <= pm_r >> 1;
          end
          OP_SAVE_PN: nn_r <= an_z ? '0 : pr_r;
          OP_SAVE_PD: dd_r <= pr_r;
          OP_POW_FIN: begin
            if (!ex_r[W-1]) begin
              if (dd_r == '0) begin
                st_r   <= ST_DIV_ZERO;
                stop_r <= 1'b1;
              end
            end else if (dd_r == '0) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end else if (an_z) begin
              stop_r <= 1'b1;
            end else if (nn_r == '0) begin
              st_r   <= ST_ZERO_DEN;
              stop_r <= 1'b1;
            end else begin
              // Negative power: take the reciprocal.
              nn_r <= dd_r;
              dd_r <= nn_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.act     = act_r;
    stat.stop    = stop_r;
    stat.div_rdy = div_done;
    stat.gy_zero = (gy_r == '0);
    stat.pm_lsb  = pm_r[0];
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // A published error carries a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.wb && cmd.op == OP_PUBLISH) && out_r.status != ST_OK) |->
      (out_r.res_num == '0 && out_r.res_den == '0))
    else $error("error result with nonzero fraction");
`endif

endmodule

### src/rfa_ctrl.sv
// ----------------------------------------------------------------------------
// rfa_ctrl
// Micro-program sequencer: steps through each action's operations and
// drives the input and result handshakes.
// ----------------------------------------------------------------------------
module rfa_ctrl import rfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output rfa_cmd_t  cmd,
  input  rfa_stat_t stat
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

  state_t             state_r, state_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  op_t                op_r, op_nxt, cur_op;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      op_r        <= OP_END;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd           = '{op: op_r, go: 1'b0, wb: 1'b0};
    cur_op        = prog_op(stat.act, pc_r);
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd       = '{op: OP_LOAD, go: 1'b0, wb: 1'b1};
          pc_nxt    = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (stat.stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd    = '{op: cur_op, go: 1'b1, wb: 1'b0};
          op_nxt = cur_op;
          unique case (op_kind(cur_op))
            K_ONE: begin
              cmd.wb = 1'b1;
              pc_nxt = pc_r + 1'b1;
            end
            K_MUL: state_nxt = S_MUL_WB;
            K_DIV: state_nxt = S_DIV_WAIT;
            K_GCD: state_nxt = S_GCD_TEST;
            K_POW: begin
              cnt_nxt   = '0;
              state_nxt = S_POW_R;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL_WB: begin
        cmd.wb = 1'b1;
        if (op_r == OP_PMUL_R) begin
          state_nxt = S_POW_B;
        end else if (op_r == OP_PMUL_B) begin
          if (cnt_r == CNT_LAST) begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_ISSUE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_POW_R;
          end
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_DIV_WAIT: begin
        if (stat.div_rdy) begin
          cmd.wb = 1'b1;
          if (op_r == OP_GREM) begin
            state_nxt = S_GCD_TEST;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_GCD_TEST: begin
        // Euclid: one remainder per pass until it reaches zero.
        if (stat.gy_zero) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = S_ISSUE;
        end else begin
          cmd       = '{op: OP_GREM, go: 1'b1, wb: 1'b0};
          op_nxt    = OP_GREM;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_POW_R: begin
        if (stat.pm_lsb) begin
          cmd       = '{op: OP_PMUL_R, go: 1'b1, wb: 1'b0};
          op_nxt    = OP_PMUL_R;
          state_nxt = S_MUL_WB;
        end else begin
          state_nxt = S_POW_B;
        end
      end
      S_POW_B: begin
        cmd       = '{op: OP_PMUL_B, go: 1'b1, wb: 1'b0};
        op_nxt    = OP_PMUL_B;
        state_nxt = S_MUL_WB;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd           = '{op: OP_PUBLISH, go: 1'b0, wb: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // The output register is only overwritten once its transaction is gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && cmd.op == OP_PUBLISH) |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while still stalled");

  // The program counter stays within the longest program.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE && !stat.stop) |-> (pc_r < PC_BITS'(PROG_LEN)))
    else $error("program counter ran past the program");

  // Every write-back of a divide follows a finished division.
  a_div_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT && cmd.wb) |-> stat.div_rdy)
    else $error("divide result taken before the divider finished");
`endif

endmodule

### src/rational_fraction_alu_top.sv
// ----------------------------------------------------------------------------
// rational_fraction_alu_top
// Arithmetic unit for signed fractions: add, subtract, multiply, divide,
// compare and integer power, results in lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one transaction
//   holding the action, two fractions and an exponent. The result channel
//   (out_valid, out_stall, out_data) returns one transaction per input with
//   the result fraction, the compare order and a status code.
//   One item is worked on at a time; the next is taken once the current
//   one has reached the output register, even while that result is still
//   stalled. Latency depends on the action and the operands: every divide
//   runs on one shared divider at one bit per cycle, and each gcd takes
//   one such divide per Euclid step. Add runs five divides and two gcds,
//   multiply or divide six divides and three gcds; power adds
//   2 x WORD_BITS square-and-multiply steps on the shared multiplier.
//   A stalled result holds in the output register; the block finishes the
//   next item but waits to publish it. Reset empties both sides.
// ----------------------------------------------------------------------------
module rational_fraction_alu_top import rfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rfa_out_t out_data
);

  rfa_cmd_t  cmd;
  rfa_stat_t stat;

  // Sequencer.
  rfa_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic datapath.
  rfa_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
